[rtl/core/sise_pkg.sv]
// shared types and constants of the sorted interval set engine
`default_nettype none
package sise_pkg;

    localparam int MAX_RANGES = 64;
    localparam int INDEX_BITS = 32;
    localparam int ADDR_W     = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int ENTRY_W    = 2 * INDEX_BITS;

    typedef logic [INDEX_BITS-1:0] t_index;
    typedef logic [ENTRY_W-1:0]    t_entry;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_count;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_CONTAINS  = 3'd2,
        OP_INTERSECT = 3'd3,
        OP_READ      = 3'd4,
        OP_CLEAR     = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRD,
        S_SUSE,
        S_SEND,
        S_MRD,
        S_MUSE,
        S_WP,
        S_WP1,
        S_RRD,
        S_RUSE,
        S_DONE
    } t_state;

    // one access request to the range table
    typedef struct packed {
        logic   rd_en;
        t_addr  rd_addr;
        logic   wr_en;
        t_addr  wr_addr;
        t_entry wr_data;
    } t_mem_req;

endpackage
`default_nettype wire

[rtl/core/sise_if.sv]
// handshake channels of the sorted interval set engine
`default_nettype none
interface sise_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] range_first;
    logic [31:0] range_span;
    logic [5:0]  entry_number;

    modport source (output valid, output op, output range_first, output range_span,
                    output entry_number, input ready);
    modport sink (input valid, input op, input range_first, input range_span,
                  input entry_number, output ready);
endinterface

interface sise_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [6:0]  ranges_held;
    logic [31:0] entry_first;
    logic [31:0] entry_last;
    logic        entry_valid;
    logic        overflow;

    modport source (output valid, output hit, output ranges_held, output entry_first,
                    output entry_last, output entry_valid, output overflow, input ready);
    modport sink (input valid, input hit, input ranges_held, input entry_first,
                  input entry_last, input entry_valid, input overflow, output ready);
endinterface
`default_nettype wire

[rtl/core/sise_table.sv]
// range table memory, one write and one registered read per cycle
`default_nettype none
module sise_table (
    input  wire logic              i_clk,
    input  wire sise_pkg::t_mem_req i_req,
    output sise_pkg::t_entry       o_rd_data
);

    sise_pkg::t_entry r_mem [sise_pkg::MAX_RANGES];
    sise_pkg::t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[rtl/core/sorted_interval_set_engine_top.sv]
// Sorted interval set engine: keeps up to 64 disjoint inclusive ranges in ascending order
// in one single-port-read, single-port-write memory and runs one operation per input word.
// Every table walk issues the read of an entry and then uses it before reading the next.
// Contains and intersect walk every entry; add and remove scan the entries, then move the
// table tail and write the merged or cut pieces. No clearing pass is needed after reset.
// One result word comes out per input word; a new word is taken while a result waits.
`default_nettype none
module sorted_interval_set_engine_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sise_in_if.sink   i_in,
    sise_out_if.source o_out
);

    localparam int IW = sise_pkg::INDEX_BITS;
    localparam int CW = sise_pkg::CNT_W;

    sise_pkg::t_state   r_state, n_state;
    sise_pkg::t_op      r_op, n_op;
    sise_pkg::t_index   r_f, n_f, r_l, n_l, r_mf, n_mf, r_ml, n_ml;
    sise_pkg::t_addr    r_num, n_num;
    sise_pkg::t_count   r_count, n_count, r_i, n_i, r_lo, n_lo, r_hi, n_hi;
    sise_pkg::t_count   r_n, n_n, r_j, n_j, r_d, n_d, r_new, n_new;
    logic               r_in, n_in, r_up, n_up;
    logic [1:0]         r_keep, n_keep;
    sise_pkg::t_entry   r_p0, n_p0, r_p1, n_p1;
    logic               r_hit, n_hit, r_ovf, n_ovf, r_ev, n_ev;
    sise_pkg::t_index   r_ef, n_ef, r_el, n_el;
    logic               r_o_valid, n_o_valid;
    logic               r_o_hit, n_o_hit, r_o_ev, n_o_ev, r_o_ovf, n_o_ovf;
    sise_pkg::t_count   r_o_held, n_o_held;
    sise_pkg::t_index   r_o_ef, n_o_ef, r_o_el, n_o_el;

    sise_pkg::t_mem_req mem_req;
    sise_pkg::t_entry   rd_data;

    sise_table u_table (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // next state, table walk and result assembly
    always_comb begin
        logic [IW:0]        sum;
        sise_pkg::t_index   a, b;
        logic [IW:0]        a33, b_p1, f33, l_p1;
        sise_pkg::t_count   span_n;
        logic [1:0]         keep;
        sise_pkg::t_entry   p0, p1;
        logic               hl, hr, cont;
        logic [CW:0]        grow, limit;

        n_state = r_state; n_op = r_op; n_f = r_f; n_l = r_l; n_mf = r_mf; n_ml = r_ml;
        n_num = r_num; n_count = r_count; n_i = r_i; n_lo = r_lo; n_hi = r_hi;
        n_n = r_n; n_j = r_j; n_d = r_d; n_new = r_new; n_in = r_in; n_up = r_up;
        n_keep = r_keep; n_p0 = r_p0; n_p1 = r_p1;
        n_hit = r_hit; n_ovf = r_ovf; n_ev = r_ev; n_ef = r_ef; n_el = r_el;
        n_o_valid = r_o_valid & ~o_out.ready;
        n_o_hit = r_o_hit; n_o_ev = r_o_ev; n_o_ovf = r_o_ovf; n_o_held = r_o_held;
        n_o_ef = r_o_ef; n_o_el = r_o_el;
        mem_req = '0;
        i_in.ready = (r_state == sise_pkg::S_IDLE);

        sum = {1'b0, i_in.range_first} + {1'b0, i_in.range_span};
        a = rd_data[sise_pkg::ENTRY_W-1:IW];
        b = rd_data[IW-1:0];
        a33 = {1'b0, a};
        b_p1 = {1'b0, b} + (IW+1)'(1);
        f33 = {1'b0, r_f};
        l_p1 = {1'b0, r_l} + (IW+1)'(1);
        span_n = r_hi - r_lo;
        keep = 2'd0; p0 = '0; p1 = '0; cont = 1'b0;
        hl = r_mf < r_f;
        hr = r_ml > r_l;
        grow = '0; limit = '0;

        case (r_state)
            sise_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_op = sise_pkg::t_op'(i_in.op);
                    n_f = i_in.range_first;
                    n_l = sum[IW] ? '1 : sum[IW-1:0];
                    n_num = i_in.entry_number;
                    n_i = '0; n_lo = '0; n_hi = '0; n_n = '0; n_in = 1'b0;
                    n_hit = 1'b0; n_ovf = 1'b0; n_ev = 1'b0; n_ef = '0; n_el = '0;
                    case (sise_pkg::t_op'(i_in.op))
                        sise_pkg::OP_ADD, sise_pkg::OP_REMOVE,
                        sise_pkg::OP_CONTAINS, sise_pkg::OP_INTERSECT: n_state = sise_pkg::S_SRD;
                        sise_pkg::OP_READ: n_state = sise_pkg::S_RRD;
                        sise_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_state = sise_pkg::S_DONE;
                        end
                        default: n_state = sise_pkg::S_DONE;
                    endcase
                end
            end
            // scan: issue read of entry i
            sise_pkg::S_SRD: begin
                if (r_i == r_count) begin
                    n_state = sise_pkg::S_SEND;
                end else begin
                    mem_req.rd_en = 1'b1;
                    mem_req.rd_addr = r_i[sise_pkg::ADDR_W-1:0];
                    n_state = sise_pkg::S_SUSE;
                end
            end
            // scan: evaluate entry i
            sise_pkg::S_SUSE: begin
                n_state = sise_pkg::S_SRD;
                n_i = r_i + CW'(1);
                case (r_op)
                    sise_pkg::OP_ADD: begin
                        if (!r_in && (b_p1 < f33)) begin
                            n_lo = r_i + CW'(1);
                            n_hi = r_i + CW'(1);
                        end else if (a33 <= l_p1) begin
                            if (!r_in) n_mf = (a < r_f) ? a : r_f;
                            n_in = 1'b1;
                            n_ml = (b > r_l) ? b : r_l;
                            n_hi = r_i + CW'(1);
                        end else begin
                            n_state = sise_pkg::S_SEND;
                        end
                    end
                    sise_pkg::OP_REMOVE: begin
                        if (!r_in && (b < r_f)) begin
                            n_lo = r_i + CW'(1);
                            n_hi = r_i + CW'(1);
                        end else if (a <= r_l) begin
                            if (!r_in) n_mf = a;
                            n_in = 1'b1;
                            n_ml = b;
                            n_hi = r_i + CW'(1);
                        end else begin
                            n_state = sise_pkg::S_SEND;
                        end
                    end
                    sise_pkg::OP_CONTAINS: begin
                        if ((r_f >= a) && (r_f <= b)) n_hit = 1'b1;
                    end
                    sise_pkg::OP_INTERSECT: begin
                        if (!((b < r_f) || (a > r_l))) begin
                            mem_req.wr_en = 1'b1;
                            mem_req.wr_addr = r_n[sise_pkg::ADDR_W-1:0];
                            mem_req.wr_data = {((a < r_f) ? r_f : a), ((b > r_l) ? r_l : b)};
                            n_n = r_n + CW'(1);
                        end
                    end
                    default: n_state = sise_pkg::S_SEND;
                endcase
            end
            // plan the table update
            sise_pkg::S_SEND: begin
                n_state = sise_pkg::S_DONE;
                case (r_op)
                    sise_pkg::OP_INTERSECT: n_count = r_n;
                    sise_pkg::OP_ADD: begin
                        keep = 2'd1;
                        p0 = r_in ? {r_mf, r_ml} : {r_f, r_l};
                        cont = 1'b1;
                    end
                    sise_pkg::OP_REMOVE: begin
                        p1 = {r_l + IW'(1), r_ml};
                        p0 = hl ? {r_mf, r_f - IW'(1)} : p1;
                        keep = {1'b0, hl} + {1'b0, hr};
                        cont = r_in;
                    end
                    default: cont = 1'b0;
                endcase
                if (cont) begin
                    grow = {1'b0, r_count} + (CW+1)'(keep);
                    limit = (CW+1)'(sise_pkg::MAX_RANGES) + {1'b0, span_n};
                    if (grow > limit) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_keep = keep;
                        n_p0 = p0;
                        n_p1 = p1;
                        n_new = r_count + CW'(keep) - span_n;
                        if (CW'(keep) > span_n) begin
                            n_up = 1'b1;
                            n_j = r_count;
                            n_state = sise_pkg::S_MRD;
                        end else if (CW'(keep) < span_n) begin
                            n_up = 1'b0;
                            n_j = r_hi;
                            n_d = span_n - CW'(keep);
                            n_state = sise_pkg::S_MRD;
                        end else begin
                            n_state = sise_pkg::S_WP;
                        end
                    end
                end
            end
            // move the tail: issue read
            sise_pkg::S_MRD: begin
                if (r_up) begin
                    if (r_j == r_hi) begin
                        n_state = sise_pkg::S_WP;
                    end else begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = sise_pkg::t_addr'(r_j - CW'(1));
                        n_state = sise_pkg::S_MUSE;
                    end
                end else begin
                    if (r_j == r_count) begin
                        n_state = sise_pkg::S_WP;
                    end else begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = r_j[sise_pkg::ADDR_W-1:0];
                        n_state = sise_pkg::S_MUSE;
                    end
                end
            end
            // move the tail: write entry to its new slot
            sise_pkg::S_MUSE: begin
                mem_req.wr_en = 1'b1;
                mem_req.wr_data = rd_data;
                if (r_up) begin
                    mem_req.wr_addr = r_j[sise_pkg::ADDR_W-1:0];
                    n_j = r_j - CW'(1);
                end else begin
                    mem_req.wr_addr = sise_pkg::t_addr'(r_j - r_d);
                    n_j = r_j + CW'(1);
                end
                n_state = sise_pkg::S_MRD;
            end
            // write the merged or cut pieces
            sise_pkg::S_WP: begin
                if (r_keep != 2'd0) begin
                    mem_req.wr_en = 1'b1;
                    mem_req.wr_addr = r_lo[sise_pkg::ADDR_W-1:0];
                    mem_req.wr_data = r_p0;
                end
                if (r_keep == 2'd2) begin
                    n_state = sise_pkg::S_WP1;
                end else begin
                    n_count = r_new;
                    n_state = sise_pkg::S_DONE;
                end
            end
            sise_pkg::S_WP1: begin
                mem_req.wr_en = 1'b1;
                mem_req.wr_addr = sise_pkg::t_addr'(r_lo + CW'(1));
                mem_req.wr_data = r_p1;
                n_count = r_new;
                n_state = sise_pkg::S_DONE;
            end
            sise_pkg::S_RRD: begin
                if ({1'b0, r_num} < r_count) begin
                    mem_req.rd_en = 1'b1;
                    mem_req.rd_addr = r_num;
                    n_state = sise_pkg::S_RUSE;
                end else begin
                    n_state = sise_pkg::S_DONE;
                end
            end
            sise_pkg::S_RUSE: begin
                n_ev = 1'b1;
                n_ef = a;
                n_el = b;
                n_state = sise_pkg::S_DONE;
            end
            // hand the result word to the output register
            sise_pkg::S_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o_hit = r_hit;
                    n_o_ev = r_ev;
                    n_o_ovf = r_ovf;
                    n_o_held = r_count;
                    n_o_ef = r_ef;
                    n_o_el = r_el;
                    n_state = sise_pkg::S_IDLE;
                end
            end
            default: n_state = sise_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sise_pkg::S_IDLE;
            r_count <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // operand, walk and result registers
    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_f <= n_f; r_l <= n_l; r_mf <= n_mf; r_ml <= n_ml;
        r_num <= n_num; r_i <= n_i; r_lo <= n_lo; r_hi <= n_hi; r_n <= n_n;
        r_j <= n_j; r_d <= n_d; r_new <= n_new; r_in <= n_in; r_up <= n_up;
        r_keep <= n_keep; r_p0 <= n_p0; r_p1 <= n_p1;
        r_hit <= n_hit; r_ovf <= n_ovf; r_ev <= n_ev; r_ef <= n_ef; r_el <= n_el;
        r_o_hit <= n_o_hit; r_o_ev <= n_o_ev; r_o_ovf <= n_o_ovf; r_o_held <= n_o_held;
        r_o_ef <= n_o_ef; r_o_el <= n_o_el;
    end

    assign o_out.valid = r_o_valid;
    assign o_out.hit = r_o_hit;
    assign o_out.ranges_held = r_o_held;
    assign o_out.entry_first = r_o_ef;
    assign o_out.entry_last = r_o_el;
    assign o_out.entry_valid = r_o_ev;
    assign o_out.overflow = r_o_ovf;

endmodule
`default_nettype wire

[rtl/core/sise_checker.sv]
// port-level checks of the sorted interval set engine and their binding
`default_nettype none
module sise_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_hit,
    input wire logic [6:0] i_held,
    input wire logic       i_entry_valid,
    input wire logic       i_overflow
);

    // a waiting result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // table never reports more than its capacity
    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_held <= 7'(sise_pkg::MAX_RANGES)))
        else $error("ranges held above capacity");

    // only one kind of flag per result
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($countones({i_hit, i_entry_valid, i_overflow}) <= 1))
        else $error("conflicting result flags");

    // a full table refusal only happens at capacity
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow |-> (i_held == 7'(sise_pkg::MAX_RANGES)))
        else $error("overflow below capacity");

endmodule

bind sorted_interval_set_engine_top sise_checker u_sise_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_hit         (o_out.hit),
    .i_held        (o_out.ranges_held),
    .i_entry_valid (o_out.entry_valid),
    .i_overflow    (o_out.overflow)
);
`default_nettype wire

[verif/testbench.sv]
// self-checking testbench of the sorted interval set engine
`default_nettype none
module testbench;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sise_in_if  in_ch();
    sise_out_if out_ch();

    sorted_interval_set_engine_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    typedef struct {
        logic        hit;
        logic [6:0]  ranges_held;
        logic [31:0] entry_first;
        logic [31:0] entry_last;
        logic        entry_valid;
        logic        overflow;
    } t_answer;

    localparam logic [32:0] TOP_INDEX = 33'h0_FFFF_FFFF;

    // predictor copy of the table
    logic [32:0] set_first [sise_pkg::MAX_RANGES];
    logic [32:0] set_last  [sise_pkg::MAX_RANGES];
    int          set_count;

    t_answer answer_q[$];
    int      error_count;
    longint  cycle_count;
    int      send_gap_max;
    int      recv_gap_max;
    int      hold_cycles;

    always #2 i_clk = ~i_clk;

    // mismatch report
    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // table moves
    function automatic void close_gap(input int at, input int n);
        for (int i = at; i < set_count - n; i++) begin
            set_first[i] = set_first[i + n];
            set_last[i]  = set_last[i + n];
        end
        set_count -= n;
    endfunction

    function automatic void open_gap(input int at);
        for (int i = set_count; i > at; i--) begin
            set_first[i] = set_first[i - 1];
            set_last[i]  = set_last[i - 1];
        end
        set_count++;
    endfunction

    function automatic logic merge_range(input logic [32:0] f, input logic [32:0] l);
        int lo;
        int hi;
        lo = 0;
        while (lo < set_count && set_last[lo] + 1 < f) lo++;
        hi = lo;
        while (hi < set_count && (set_first[hi] <= l ||
               (l < TOP_INDEX && set_first[hi] == l + 1))) hi++;
        if (hi == lo) begin
            if (set_count >= sise_pkg::MAX_RANGES) return 1'b0;
            open_gap(lo);
            set_first[lo] = f;
            set_last[lo]  = l;
            return 1'b1;
        end
        if (set_first[lo] < f) f = set_first[lo];
        if (set_last[hi - 1] > l) l = set_last[hi - 1];
        if (hi - lo > 1) close_gap(lo + 1, hi - lo - 1);
        set_first[lo] = f;
        set_last[lo]  = l;
        return 1'b1;
    endfunction

    function automatic logic cut_range(input logic [32:0] f, input logic [32:0] l);
        int lo;
        int hi;
        int keep;
        logic left_part;
        logic right_part;
        logic [32:0] lf;
        logic [32:0] rl;
        lo = 0;
        keep = 0;
        while (lo < set_count && set_last[lo] < f) lo++;
        hi = lo;
        while (hi < set_count && set_first[hi] <= l) hi++;
        if (hi == lo) return 1'b1;
        left_part  = set_first[lo] < f;
        right_part = set_last[hi - 1] > l;
        lf = set_first[lo];
        rl = set_last[hi - 1];
        keep = int'(left_part) + int'(right_part);
        if (set_count - (hi - lo) + keep > sise_pkg::MAX_RANGES) return 1'b0;
        if (keep > hi - lo) open_gap(lo);
        else if (keep < hi - lo) close_gap(lo + keep, hi - lo - keep);
        if (left_part) begin
            set_first[lo] = lf;
            set_last[lo]  = f - 1;
            lo++;
        end
        if (right_part) begin
            set_first[lo] = l + 1;
            set_last[lo]  = rl;
        end
        return 1'b1;
    endfunction

    function automatic t_answer predict_answer(input logic [2:0] op, input logic [31:0] first,
                                               input logic [31:0] span,
                                               input logic [5:0] number);
        t_answer a;
        logic [32:0] f;
        logic [32:0] l;
        int n;
        a = '{default: '0};
        f = {1'b0, first};
        l = f + {1'b0, span};
        if (l > TOP_INDEX) l = TOP_INDEX;
        case (op)
            sise_pkg::OP_ADD:    a.overflow = ~merge_range(f, l);
            sise_pkg::OP_REMOVE: a.overflow = ~cut_range(f, l);
            sise_pkg::OP_CONTAINS: begin
                for (int i = 0; i < set_count; i++)
                    if (f >= set_first[i] && f <= set_last[i]) a.hit = 1'b1;
            end
            sise_pkg::OP_INTERSECT: begin
                n = 0;
                for (int i = 0; i < set_count; i++) begin
                    if (!(set_last[i] < f || set_first[i] > l)) begin
                        set_first[n] = set_first[i] < f ? f : set_first[i];
                        set_last[n]  = set_last[i] > l ? l : set_last[i];
                        n++;
                    end
                end
                set_count = n;
            end
            sise_pkg::OP_READ: begin
                if (number < set_count) begin
                    a.entry_valid = 1'b1;
                    a.entry_first = set_first[number][31:0];
                    a.entry_last  = set_last[number][31:0];
                end
            end
            sise_pkg::OP_CLEAR: set_count = 0;
            default: ;
        endcase
        a.ranges_held = set_count[6:0];
        return a;
    endfunction

    function automatic int pick_gap(input int max_gap);
        if (max_gap == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        return $urandom_range(0, max_gap);
    endfunction

    // send one word and record its expectation at acceptance
    task automatic send_word(input logic [2:0] op, input logic [31:0] first,
                             input logic [31:0] span, input logic [5:0] number);
        int gap;
        gap = pick_gap(send_gap_max);
        // step past the falling edge that dropped the previous word
        repeat (gap + 1) @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.range_first  <= first;
        in_ch.range_span   <= span;
        in_ch.entry_number <= number;
        do @(posedge i_clk); while (!in_ch.ready);
        answer_q.push_back(predict_answer(op, first, span, number));
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // receiver ready, with random stalls and an optional long hold
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else if (recv_gap_max == 0) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= (pick_gap(recv_gap_max) == 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (answer_q.size() == 0) begin
                report_error("unexpected word", 32'd0, 32'd0);
            end else begin
                want = answer_q.pop_front();
                if (out_ch.hit !== want.hit)
                    report_error("hit", out_ch.hit, want.hit);
                if (out_ch.ranges_held !== want.ranges_held)
                    report_error("ranges_held", out_ch.ranges_held, want.ranges_held);
                if (out_ch.entry_first !== want.entry_first)
                    report_error("entry_first", out_ch.entry_first, want.entry_first);
                if (out_ch.entry_last !== want.entry_last)
                    report_error("entry_last", out_ch.entry_last, want.entry_last);
                if (out_ch.entry_valid !== want.entry_valid)
                    report_error("entry_valid", out_ch.entry_valid, want.entry_valid);
                if (out_ch.overflow !== want.overflow)
                    report_error("overflow", out_ch.overflow, want.overflow);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        return $urandom();
    endfunction

    // operand spread over a small window so that ranges collide
    function automatic logic [31:0] near_index(input logic [31:0] base);
        return base + $urandom_range(0, 2000);
    endfunction

    task automatic test_directed();
        send_word(sise_pkg::OP_READ, 0, 0, 6'd0);
        send_word(sise_pkg::OP_CONTAINS, 0, 0, 0);
        send_word(sise_pkg::OP_REMOVE, 10, 5, 0);
        send_word(sise_pkg::OP_ADD, 10, 5, 0);
        send_word(sise_pkg::OP_ADD, 20, 0, 0);
        send_word(sise_pkg::OP_ADD, 16, 3, 0);
        send_word(sise_pkg::OP_ADD, 40, 9, 0);
        send_word(sise_pkg::OP_ADD, 30, 9, 0);
        send_word(sise_pkg::OP_READ, 0, 0, 6'd0);
        send_word(sise_pkg::OP_REMOVE, 12, 2, 0);
        send_word(sise_pkg::OP_READ, 0, 0, 6'd1);
        send_word(sise_pkg::OP_CONTAINS, 13, 0, 0);
        send_word(sise_pkg::OP_CONTAINS, 11, 0, 0);
        send_word(sise_pkg::OP_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0);
        send_word(sise_pkg::OP_ADD, 32'hFFFF_FF00, 32'h0000_00EF, 0);
        send_word(sise_pkg::OP_READ, 0, 0, 6'd63);
        send_word(sise_pkg::OP_INTERSECT, 11, 32'hFFFF_FFF5, 0);
        send_word(sise_pkg::OP_READ, 0, 0, 6'd2);
        send_word(sise_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 0, 0);
        send_word(3'd6, rand_word(), rand_word(), 6'd63);
        send_word(3'd7, rand_word(), rand_word(), 6'd0);
        send_word(sise_pkg::OP_INTERSECT, 0, 32'hFFFF_FFFF, 0);
        send_word(sise_pkg::OP_CLEAR, 0, 0, 0);
        send_word(sise_pkg::OP_READ, 0, 0, 6'd0);
    endtask

    // fill to capacity with isolated two-index ranges, force overflow on add, then trim and merge
    task automatic test_capacity();
        send_word(sise_pkg::OP_CLEAR, 0, 0, 0);
        for (int i = 0; i < sise_pkg::MAX_RANGES; i++)
            send_word(sise_pkg::OP_ADD, i * 4, 1, 0);
        send_word(sise_pkg::OP_ADD, 1000, 0, 0);
        send_word(sise_pkg::OP_REMOVE, 8, 0, 0);
        send_word(sise_pkg::OP_ADD, 2, 1, 0);
        send_word(sise_pkg::OP_REMOVE, 4, 1, 0);
        send_word(sise_pkg::OP_ADD, 1000, 0, 0);
        send_word(sise_pkg::OP_REMOVE, 8, 0, 0);
        send_word(sise_pkg::OP_READ, 0, 0, 6'd63);
        for (int i = 0; i < sise_pkg::MAX_RANGES; i++)
            send_word(sise_pkg::OP_READ, 0, 0, i[5:0]);
    endtask

    // mostly add and remove over a narrow window, with full-width noise
    task automatic test_random(input int count);
        logic [2:0] op;
        logic [31:0] base;
        int pick;
        base = rand_word();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) op = sise_pkg::OP_ADD;
            else if (pick < 55) op = sise_pkg::OP_REMOVE;
            else if (pick < 70) op = sise_pkg::OP_CONTAINS;
            else if (pick < 74) op = sise_pkg::OP_INTERSECT;
            else if (pick < 96) op = sise_pkg::OP_READ;
            else if (pick < 98) op = sise_pkg::OP_CLEAR;
            else op = 3'($urandom_range(6, 7));
            if ($urandom_range(0, 9) == 0)
                send_word(op, rand_word(), rand_word(), 6'($urandom()));
            else if (op == sise_pkg::OP_INTERSECT)
                send_word(op, near_index(base), $urandom_range(0, 2000), 6'($urandom()));
            else
                send_word(op, near_index(base), $urandom_range(0, 30),
                          6'($urandom_range(0, 40)));
            if ($urandom_range(0, 299) == 0) base = rand_word();
        end
    endtask

    task automatic wait_drained();
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.op           = sise_pkg::OP_CLEAR;
        in_ch.range_first  = '0;
        in_ch.range_span   = '0;
        in_ch.entry_number = '0;
        out_ch.ready       = 1'b0;
        error_count  = 0;
        cycle_count  = 0;
        set_count    = 0;
        send_gap_max = 0;
        recv_gap_max = 0;
        hold_cycles  = 0;
        for (int i = 0; i < sise_pkg::MAX_RANGES; i++) begin
            set_first[i] = '0;
            set_last[i]  = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        send_gap_max = 3;
        recv_gap_max = 3;
        test_capacity();
        // long receiver hold while the sender keeps offering words
        @(negedge i_clk);
        hold_cycles <= 400;
        send_gap_max = 0;
        test_random(30);
        send_gap_max = 4;
        recv_gap_max = 4;
        test_random(760);
        send_gap_max = 0;
        recv_gap_max = 0;
        test_random(500);
        wait_drained();

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
